>>> rtl/tcp_sack_block_tracker_defines.svh
// ----------------------------------------------------------------------------
// TCP SACK block tracker assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TCP_SACK_BLOCK_TRACKER_DEFINES_SVH
`define TCP_SACK_BLOCK_TRACKER_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define TSBT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TSBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/tsbt_pkg.sv
// ----------------------------------------------------------------------------
// TCP SACK block tracker package
// Sizes, input kinds, controller/datapath bundles and serial-number compares.
// ----------------------------------------------------------------------------
package tsbt_pkg;

    localparam int MAX_BLOCKS = 4;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SEQ_W      = 32;
    localparam int KIND_W     = 3;

    typedef logic [SEQ_W-1:0] seq_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE    = KIND_W'(0),
        KIND_DSACK   = KIND_W'(1),
        KIND_ADVANCE = KIND_W'(2),
        KIND_CLEAR   = KIND_W'(3),
        KIND_EMIT    = KIND_W'(4)
    } kind_t;

    typedef struct packed {
        logic load;
        logic dsack;
        logic clear;
        logic note_step;
        logic note_done;
        logic adv_step;
        logic adv_done;
        logic put_empty;
        logic put_dup;
        logic put_blk;
    } tsbt_ctl_t;

    typedef struct packed {
        logic sack_en;
        logic dup_pending;
        logic list_empty;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } tsbt_stat_t;

    function automatic logic sn_lt(input seq_t a, input seq_t b);
        seq_t diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

    function automatic logic sn_leq(input seq_t a, input seq_t b);
        return (a == b) || sn_lt(a, b);
    endfunction

endpackage

>>> rtl/tsbt_cmd_if.sv
// ----------------------------------------------------------------------------
// TCP SACK block tracker command channel
// Valid/ready channel carrying one tracker event per transfer.
// ----------------------------------------------------------------------------
interface tsbt_cmd_if;

    logic                        valid;
    logic                        ready;
    logic [tsbt_pkg::KIND_W-1:0] kind;
    logic [tsbt_pkg::SEQ_W-1:0]  range_start;
    logic [tsbt_pkg::SEQ_W-1:0]  range_end;
    logic [tsbt_pkg::SEQ_W-1:0]  receive_next;

    modport source (
        output valid,
        output kind,
        output range_start,
        output range_end,
        output receive_next,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  range_start,
        input  range_end,
        input  receive_next,
        output ready
    );

endinterface

>>> rtl/tsbt_rsp_if.sv
// ----------------------------------------------------------------------------
// TCP SACK block tracker result channel
// Valid/ready channel carrying one emitted SACK block, or an empty result, per transfer.
// ----------------------------------------------------------------------------
interface tsbt_rsp_if;

    logic                       valid;
    logic                       ready;
    logic                       block_valid;
    logic [tsbt_pkg::SEQ_W-1:0] block_start;
    logic [tsbt_pkg::SEQ_W-1:0] block_end;
    logic                       is_duplicate;
    logic                       last_block;

    modport source (
        output valid,
        output block_valid,
        output block_start,
        output block_end,
        output is_duplicate,
        output last_block,
        input  ready
    );

    modport sink (
        input  valid,
        input  block_valid,
        input  block_start,
        input  block_end,
        input  is_duplicate,
        input  last_block,
        output ready
    );

endinterface

>>> rtl/tsbt_ctrl.sv
// ----------------------------------------------------------------------------
// TCP SACK block tracker controller
// Accepts events, sequences list scans and paces emitted blocks.
// ----------------------------------------------------------------------------
module tsbt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic [tsbt_pkg::KIND_W-1:0] cmd_kind,
    output logic                        cmd_ready,
    input  tsbt_pkg::tsbt_stat_t        stat,
    output tsbt_pkg::tsbt_ctl_t         ctl
);
    import tsbt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOTE,
        ST_ADV,
        ST_EMPTY,
        ST_DUP,
        ST_BLK
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_kind)
                        KIND_NOTE:
                        begin
                            ctl.load   = 1'b1;
                            state_next = ST_NOTE;
                        end
                        KIND_DSACK:
                        begin
                            ctl.dsack = 1'b1;
                        end
                        KIND_ADVANCE:
                        begin
                            ctl.load   = 1'b1;
                            state_next = ST_ADV;
                        end
                        KIND_CLEAR:
                        begin
                            ctl.clear = 1'b1;
                        end
                        KIND_EMIT:
                        begin
                            ctl.load = 1'b1;
                            if (!stat.sack_en || (!stat.dup_pending && stat.list_empty))
                            begin
                                state_next = ST_EMPTY;
                            end
                            else if (stat.dup_pending)
                            begin
                                state_next = ST_DUP;
                            end
                            else
                            begin
                                state_next = ST_BLK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NOTE:
            begin
                if (stat.scan_done)
                begin
                    ctl.note_done = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ctl.note_step = 1'b1;
                end
            end
            ST_ADV:
            begin
                if (stat.scan_done)
                begin
                    ctl.adv_done = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctl.adv_step = 1'b1;
                end
            end
            ST_EMPTY:
            begin
                if (stat.out_free)
                begin
                    ctl.put_empty = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DUP:
            begin
                if (stat.out_free)
                begin
                    ctl.put_dup = 1'b1;
                    state_next  = stat.list_empty ? ST_IDLE : ST_BLK;
                end
            end
            ST_BLK:
            begin
                if (stat.out_free)
                begin
                    ctl.put_blk = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/tsbt_dp.sv
// ----------------------------------------------------------------------------
// TCP SACK block tracker datapath
// Block table, D-SACK range, scan pointers and the result register.
// ----------------------------------------------------------------------------
module tsbt_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tsbt_pkg::SEQ_W-1:0] range_start,
    input  logic [tsbt_pkg::SEQ_W-1:0] range_end,
    input  logic [tsbt_pkg::SEQ_W-1:0] receive_next,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  tsbt_pkg::tsbt_ctl_t        ctl,
    output tsbt_pkg::tsbt_stat_t       stat,
    tsbt_rsp_if.source                 rsp
);
    import tsbt_pkg::*;

    seq_t             starts_reg [MAX_BLOCKS];
    seq_t             starts_next[MAX_BLOCKS];
    seq_t             ends_reg   [MAX_BLOCKS];
    seq_t             ends_next  [MAX_BLOCKS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    seq_t             dup_start_reg;
    seq_t             dup_start_next;
    seq_t             dup_end_reg;
    seq_t             dup_end_next;
    logic             dup_pending_reg;
    logic             dup_pending_next;
    logic             sack_en_reg;
    logic             sack_en_next;
    seq_t             rs_reg;
    seq_t             rs_next;
    seq_t             re_reg;
    seq_t             re_next;
    seq_t             rn_reg;
    seq_t             rn_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] kept_reg;
    logic [CNT_W-1:0] kept_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_bv_reg;
    logic             out_bv_next;
    seq_t             out_start_reg;
    seq_t             out_start_next;
    seq_t             out_end_reg;
    seq_t             out_end_next;
    logic             out_dup_reg;
    logic             out_dup_next;
    logic             out_last_reg;
    logic             out_last_next;

    seq_t             cur_start;
    seq_t             cur_end;
    logic             keep_note;
    logic             keep_adv;
    logic [CNT_W-1:0] idx_inc;
    logic             blk_last;

    assign cur_start = starts_reg[idx_reg[IDX_W-1:0]];
    assign cur_end   = ends_reg[idx_reg[IDX_W-1:0]];
    assign keep_note = !(sn_leq(cur_start, re_reg) && sn_leq(rs_reg, cur_end))
                       && (kept_reg < CNT_W'(MAX_BLOCKS - 1));
    assign keep_adv  = sn_lt(rn_reg, cur_end);
    assign idx_inc   = CNT_W'(idx_reg + 1'b1);
    assign blk_last  = (idx_inc == count_reg)
                       || (CNT_W'(idx_inc + CNT_W'(dup_pending_reg)) == CNT_W'(MAX_BLOCKS));

    assign stat.sack_en     = sack_en_reg;
    assign stat.dup_pending = dup_pending_reg;
    assign stat.list_empty  = (count_reg == '0);
    assign stat.scan_done   = (idx_reg == count_reg);
    assign stat.out_free    = !out_valid_reg || rsp.ready;
    assign stat.emit_last   = blk_last;

    assign rsp.valid        = out_valid_reg;
    assign rsp.block_valid  = out_bv_reg;
    assign rsp.block_start  = out_start_reg;
    assign rsp.block_end    = out_end_reg;
    assign rsp.is_duplicate = out_dup_reg;
    assign rsp.last_block   = out_last_reg;

    always_comb
    begin
        starts_next      = starts_reg;
        ends_next        = ends_reg;
        count_next       = count_reg;
        dup_start_next   = dup_start_reg;
        dup_end_next     = dup_end_reg;
        dup_pending_next = dup_pending_reg;
        sack_en_next     = cfg_we ? cfg_wdata : sack_en_reg;
        rs_next          = rs_reg;
        re_next          = re_reg;
        rn_next          = rn_reg;
        idx_next         = idx_reg;
        kept_next        = kept_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_bv_next      = out_bv_reg;
        out_start_next   = out_start_reg;
        out_end_next     = out_end_reg;
        out_dup_next     = out_dup_reg;
        out_last_next    = out_last_reg;

        if (ctl.load)
        begin
            rs_next   = range_start;
            re_next   = range_end;
            rn_next   = receive_next;
            idx_next  = '0;
            kept_next = '0;
        end

        if (ctl.dsack && sack_en_reg && sn_lt(range_start, range_end))
        begin
            dup_start_next   = range_start;
            dup_end_next     = range_end;
            dup_pending_next = 1'b1;
        end

        if (ctl.clear)
        begin
            count_next       = '0;
            dup_pending_next = 1'b0;
        end

        if ((ctl.note_step && keep_note) || (ctl.adv_step && keep_adv))
        begin
            starts_next[kept_reg[IDX_W-1:0]] = cur_start;
            ends_next[kept_reg[IDX_W-1:0]]   = cur_end;
            kept_next                        = CNT_W'(kept_reg + 1'b1);
        end

        if (ctl.note_step || ctl.adv_step || ctl.put_blk)
        begin
            idx_next = idx_inc;
        end

        if (ctl.note_done)
        begin
            starts_next[0] = rs_reg;
            ends_next[0]   = re_reg;
            for (int j = 1; j < MAX_BLOCKS; j++)
            begin
                starts_next[j] = starts_reg[j-1];
                ends_next[j]   = ends_reg[j-1];
            end
            count_next = CNT_W'(kept_reg + 1'b1);
        end

        if (ctl.adv_done)
        begin
            count_next = kept_reg;
        end

        if (ctl.put_empty)
        begin
            out_valid_next = 1'b1;
            out_bv_next    = 1'b0;
            out_start_next = '0;
            out_end_next   = '0;
            out_dup_next   = 1'b0;
            out_last_next  = 1'b1;
        end

        if (ctl.put_dup)
        begin
            out_valid_next = 1'b1;
            out_bv_next    = 1'b1;
            out_start_next = dup_start_reg;
            out_end_next   = dup_end_reg;
            out_dup_next   = 1'b1;
            out_last_next  = (count_reg == '0);
        end

        if (ctl.put_blk)
        begin
            out_valid_next = 1'b1;
            out_bv_next    = 1'b1;
            out_start_next = cur_start;
            out_end_next   = cur_end;
            out_dup_next   = 1'b0;
            out_last_next  = blk_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            dup_start_reg   <= '0;
            dup_end_reg     <= '0;
            dup_pending_reg <= 1'b0;
            sack_en_reg     <= 1'b0;
            idx_reg         <= '0;
            kept_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            dup_start_reg   <= dup_start_next;
            dup_end_reg     <= dup_end_next;
            dup_pending_reg <= dup_pending_next;
            sack_en_reg     <= sack_en_next;
            idx_reg         <= idx_next;
            kept_reg        <= kept_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        starts_reg    <= starts_next;
        ends_reg      <= ends_next;
        rs_reg        <= rs_next;
        re_reg        <= re_next;
        rn_reg        <= rn_next;
        out_bv_reg    <= out_bv_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_dup_reg   <= out_dup_next;
        out_last_reg  <= out_last_next;
    end

endmodule

>>> rtl/tcp_sack_block_tracker.sv
// ----------------------------------------------------------------------------
// TCP SACK block tracker
// Newest-first SACK block list with one pending D-SACK range.
//
//   Channel   Direction  Handshake     Carries
//   cmd       in         valid/ready   kind, range_start, range_end, receive_next
//   rsp       out        valid/ready   block_valid, block_start, block_end,
//                                      is_duplicate, last_block
//   cfg       in         cfg_we        sack_enabled in cfg_wdata
//
// D-SACK and clear finish as they are accepted. Note block and advance each
// scan the stored blocks (at most MAX_BLOCKS) and then update the list:
// the controller walks the table one entry a cycle.
// Emit loads its results one at a time, paced by the result register.
// Reset clears the list and the D-SACK range at once; no clearing pass.
// A stalled result holds in the result register; a new event is taken once
// the last result of an emit is in that register.
// ----------------------------------------------------------------------------
`include "tcp_sack_block_tracker_defines.svh"

module tcp_sack_block_tracker (
    input  logic        clk,
    input  logic        rst_n,
    tsbt_cmd_if.sink    cmd,
    tsbt_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import tsbt_pkg::*;

    tsbt_ctl_t  ctl;
    tsbt_stat_t stat;

    tsbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_kind  (cmd.kind),
        .cmd_ready (cmd.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    tsbt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .range_start  (cmd.range_start),
        .range_end    (cmd.range_end),
        .receive_next (cmd.receive_next),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ctl          (ctl),
        .stat         (stat),
        .rsp          (rsp)
    );

    `TSBT_ASSERT_ALWAYS(a_one_cmd, clk, rst_n, $onehot0(ctl), "more than one datapath command")
    `TSBT_ASSERT_IMPLY(a_put_free, clk, rst_n, ctl.put_empty || ctl.put_dup || ctl.put_blk, stat.out_free, "result loaded over a held result")
    `TSBT_ASSERT_IMPLY(a_idle_no_work, clk, rst_n, cmd.ready, !(ctl.note_step || ctl.adv_step || ctl.put_blk || ctl.put_dup || ctl.put_empty), "work issued while taking events")

endmodule
